/* design/ssmv_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssmv_pkg
// Types, codes and fixed-point helpers for the symmetric sparse mat-vec core.
// ----------------------------------------------------------------------------
package ssmv_pkg;

  // Field widths fixed by the request format
  localparam int IDX_W  = 12;
  localparam int VAL_W  = 32;
  localparam int ACC_W  = 48;
  localparam int VLEN_W = 13;
  localparam int PROD_W = 2 * VAL_W;

  // Configuration register map
  localparam int          CFG_ADDR_W    = 2;
  localparam int          CFG_DATA_W    = 32;
  localparam logic [1:0]  REG_VLEN_ADDR = 2'd0;
  localparam logic [12:0] VLEN_RESET    = 13'd4096;

  // Function codes of a request
  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_LOAD  = 2'd1,
    FUNC_APPLY = 2'd2,
    FUNC_READ  = 2'd3
  } func_t;

  typedef struct packed {
    logic [1:0]              func;
    logic [IDX_W-1:0]        row_index;
    logic [IDX_W-1:0]        col_index;
    logic signed [VAL_W-1:0] data_value;
  } ssmv_in_t;

  typedef struct packed {
    logic                    status;
    logic signed [ACC_W-1:0] read_value;
  } ssmv_out_t;

  // Drop 16 fraction bits (floor) and clamp to signed Q16.16
  function automatic logic signed [VAL_W-1:0] sat_q16(input logic signed [PROD_W-1:0] p);
    logic [PROD_W-17:0] s;
    logic signed [VAL_W-1:0] r;
    s = p[PROD_W-1:16];
    if (s[PROD_W-17:VAL_W-1] == '0 || s[PROD_W-17:VAL_W-1] == '1) begin
      r = s[VAL_W-1:0];
    end else if (s[PROD_W-17]) begin
      r = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(VAL_W-1){1'b1}}};
    end
    return r;
  endfunction

  // Add a Q16.16 term to a 48-bit accumulator with saturation
  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [VAL_W-1:0] d);
    logic [ACC_W:0] s;
    logic signed [ACC_W-1:0] r;
    s = {a[ACC_W-1], a} + {{(ACC_W-VAL_W+1){d[VAL_W-1]}}, d};
    if (s[ACC_W] == s[ACC_W-1]) begin
      r = s[ACC_W-1:0];
    end else if (s[ACC_W]) begin
      r = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(ACC_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* design/symmetric_sparse_matvec_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// From accept to result: load writes the vector RAM, read reads the accumulator RAM,
// apply does two read-modify-writes per nonzero on the single-port accumulator RAM,
// clear zeroes it, and an out-of-range request goes straight to the result. One
// request at a time, until the result is registered. Output register holds a result.
// Reset (rst_n low, synchronous) starts a zeroing sweep of all MAX_LENGTH accumulator
// RAM entries; in_stall stays high until it ends.
// ----------------------------------------------------------------------------
// symmetric_sparse_matvec_core
// Symmetric COO sparse matrix times dense vector, Q16.16 data, 48-bit sums.
// ----------------------------------------------------------------------------
module symmetric_sparse_matvec_core #(
  parameter int MAX_LENGTH = 4096
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // request channel
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire ssmv_pkg::ssmv_in_t                  in_data,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output ssmv_pkg::ssmv_out_t                      out_data,
  // configuration port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [ssmv_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire logic [ssmv_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [ssmv_pkg::CFG_DATA_W-1:0]          prdata,
  output logic                                     pready
);
  import ssmv_pkg::*;

  localparam int AW   = $clog2(MAX_LENGTH);
  localparam int LW0  = $clog2(MAX_LENGTH + 1);
  localparam int LW   = (LW0 > VLEN_W) ? LW0 : VLEN_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_LENGTH - 1);
  localparam logic [LW-1:0] MAX_LIM   = LW'(MAX_LENGTH);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_CLR  = 9'b000000010,
    ST_LDV  = 9'b000000100,
    ST_RDV  = 9'b000001000,
    ST_MUL  = 9'b000010000,
    ST_WRA  = 9'b000100000,
    ST_RDA  = 9'b001000000,
    ST_WRB  = 9'b010000000,
    ST_DONE = 9'b100000000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [VLEN_W-1:0]        vlen_r, vlen_nxt;
  logic [AW-1:0]            clr_cnt_r, clr_cnt_nxt;
  logic                     clr_reply_r, clr_reply_nxt;
  logic                     out_valid_r, out_valid_nxt;
  ssmv_out_t                out_data_r, out_data_nxt;
  ssmv_in_t                 item_r, item_nxt;
  logic                     status_r, status_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [VAL_W-1:0]  vec_q_r;
  logic signed [ACC_W-1:0]  acc_q_r;

  logic signed [VAL_W-1:0]  vec_mem [MAX_LENGTH];
  logic signed [ACC_W-1:0]  acc_mem [MAX_LENGTH];

  logic                     in_acc, cfg_wr;
  logic [LW-1:0]            lim, in_row_w, in_col_w, row_w, col_w;
  logic                     row_bad, col_bad;
  logic [AW-1:0]            row_a, col_a;
  logic                     vec_we, vec_re, acc_we, acc_re, mul_en;
  logic [AW-1:0]            vec_addr, acc_addr;
  logic signed [ACC_W-1:0]  acc_sum, acc_wdata;

  // Handshake and register port
  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pready    = 1'b1;
  assign prdata    = CFG_DATA_W'(vlen_r);
  assign cfg_wr    = psel && penable && pwrite && (paddr == REG_VLEN_ADDR);
  assign vlen_nxt  = cfg_wr ? pwdata[VLEN_W-1:0] : vlen_r;

  // Range check against the usable length
  assign lim      = (LW'(vlen_r) < MAX_LIM) ? LW'(vlen_r) : MAX_LIM;
  assign in_row_w = LW'(in_data.row_index);
  assign in_col_w = LW'(in_data.col_index);
  assign row_bad  = (in_row_w >= lim);
  assign col_bad  = (in_col_w >= lim);
  assign row_w    = LW'(item_r.row_index);
  assign col_w    = LW'(item_r.col_index);
  assign row_a    = row_w[AW-1:0];
  assign col_a    = col_w[AW-1:0];

  // Shared saturating accumulate path
  assign acc_sum   = sat_acc(acc_q_r, sat_q16(prod_r));
  assign acc_wdata = (state_r == ST_CLR) ? '0 : acc_sum;

  // Memory port controls per sequencer step
  always_comb begin
    vec_we   = (state_r == ST_LDV);
    vec_re   = (state_r == ST_RDV) || (state_r == ST_MUL);
    vec_addr = (state_r == ST_RDV) ? col_a : row_a;
    acc_we   = (state_r == ST_CLR) || (state_r == ST_WRA) || (state_r == ST_WRB);
    acc_re   = (state_r == ST_RDV) || (state_r == ST_RDA);
    mul_en   = (state_r == ST_MUL) || (state_r == ST_WRA);
    case (state_r)
      ST_CLR:  acc_addr = clr_cnt_r;
      ST_RDV:  acc_addr = row_a;
      ST_WRA:  acc_addr = row_a;
      ST_RDA:  acc_addr = (item_r.func == FUNC_READ) ? row_a : col_a;
      ST_WRB:  acc_addr = col_a;
      default: acc_addr = row_a;
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    clr_reply_nxt = clr_reply_r;
    item_nxt      = item_r;
    status_nxt    = status_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    prod_nxt      = mul_en ? (item_r.data_value * vec_q_r) : prod_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          item_nxt = in_data;
          case (in_data.func)
            FUNC_CLEAR: begin
              status_nxt    = 1'b0;
              clr_cnt_nxt   = '0;
              clr_reply_nxt = 1'b1;
              state_nxt     = ST_CLR;
            end
            FUNC_LOAD: begin
              status_nxt = row_bad;
              state_nxt  = row_bad ? ST_DONE : ST_LDV;
            end
            FUNC_APPLY: begin
              status_nxt = row_bad || col_bad;
              state_nxt  = (row_bad || col_bad) ? ST_DONE : ST_RDV;
            end
            default: begin
              status_nxt = row_bad;
              state_nxt  = row_bad ? ST_DONE : ST_RDA;
            end
          endcase
        end
      end
      ST_CLR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST_ADDR) begin
          clr_cnt_nxt = '0;
          state_nxt   = clr_reply_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_LDV:  state_nxt = ST_DONE;
      ST_RDV:  state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_WRA;
      ST_WRA:  state_nxt = ST_RDA;
      ST_RDA:  state_nxt = (item_r.func == FUNC_READ) ? ST_DONE : ST_WRB;
      ST_WRB:  state_nxt = ST_DONE;
      ST_DONE: begin
        // Hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.status     = status_r;
          out_data_nxt.read_value = (item_r.func == FUNC_READ && !status_r) ? acc_q_r : '0;
          state_nxt               = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_cnt_r   <= '0;
      clr_reply_r <= 1'b0;
      out_valid_r <= 1'b0;
      vlen_r      <= VLEN_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_reply_r <= clr_reply_nxt;
      out_valid_r <= out_valid_nxt;
      vlen_r      <= vlen_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    status_r   <= status_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
  end

  // Vector RAM, single port
  always_ff @(posedge clk) begin
    if (vec_we) begin
      vec_mem[vec_addr] <= item_r.data_value;
    end else if (vec_re) begin
      vec_q_r <= vec_mem[vec_addr];
    end
  end

  // Accumulator RAM, single port
  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[acc_addr] <= acc_wdata;
    end else if (acc_re) begin
      acc_q_r <= acc_mem[acc_addr];
    end
  end

endmodule
`default_nettype wire
